[design/cubemap_to_equirect_address_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the cubemap to equirectangular address generator
// Concurrent checks clocked on clk; they compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef CUBEMAP_TO_EQUIRECT_ADDRESS_ASSERT_SVH
`define CUBEMAP_TO_EQUIRECT_ADDRESS_ASSERT_SVH

`ifndef SYNTHESIS
`define C2E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define C2E_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define C2E_ASSERT(lbl, prop, msg)
`define C2E_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[design/c2e_pkg.sv]
// ----------------------------------------------------------------------------
// Cubemap to equirectangular address generator: shared definitions
// Word types, cell state types, constants and helper functions.
// ----------------------------------------------------------------------------
package c2e_pkg;

  localparam int C2E_ANGLE_BITS = 16;
  localparam int C2E_MAX_FACE_SIZE = 4096;
  localparam int C2E_MAX_SOURCE_WIDTH = 8192;

  localparam int C2E_CFG_IDX_W = 2;
  localparam int C2E_CFG_W = 14;
  localparam logic [C2E_CFG_IDX_W-1:0] C2E_REG_FACE_SIZE = 2'd0;
  localparam logic [C2E_CFG_IDX_W-1:0] C2E_REG_SOURCE_WIDTH = 2'd1;
  localparam logic [C2E_CFG_IDX_W-1:0] C2E_REG_SOURCE_HEIGHT = 2'd2;

  localparam logic [2:0] C2E_FACE_PX = 3'd0;
  localparam logic [2:0] C2E_FACE_NX = 3'd1;
  localparam logic [2:0] C2E_FACE_PY = 3'd2;
  localparam logic [2:0] C2E_FACE_NY = 3'd3;
  localparam logic [2:0] C2E_FACE_PZ = 3'd4;
  localparam logic [2:0] C2E_FACE_NZ = 3'd5;

  localparam int C2E_DIV_W = 28;
  localparam int C2E_DIV_STEPS = C2E_DIV_W;
  localparam int C2E_REM_W = 14;
  localparam int C2E_CORD_W = 36;
  localparam int C2E_CORD_STEPS = 30;
  localparam int C2E_SQ_W = 32;
  localparam int C2E_SQRT_STEPS = 16;

  localparam logic signed [15:0] C2E_UNIT = 16'sd16384;
  localparam logic [31:0] C2E_HALF_TURN = 32'h8000_0000;

  localparam logic [31:0] C2E_ATAN_TURNS [0:C2E_CORD_STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic [2:0]  face;
    logic [11:0] column;
    logic [11:0] row;
  } in_word_t;

  typedef struct packed {
    logic [12:0] source_column;
    logic [11:0] source_row;
    logic [24:0] source_index;
    logic [26:0] target_index;
  } out_word_t;

  typedef struct packed {
    logic [C2E_REM_W-1:0] rem;
    logic [C2E_DIV_W-1:0] num;
    logic [C2E_DIV_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic signed [C2E_CORD_W-1:0] x;
    logic signed [C2E_CORD_W-1:0] y;
    logic [31:0]                  ang;
    logic                         zero;
  } cord_t;

  typedef struct packed {
    logic [C2E_SQ_W-1:0] n;
    logic [C2E_SQ_W-1:0] r;
  } sqrt_t;

  function automatic logic signed [15:0] face_coord_sat(input logic [C2E_DIV_W-1:0] q);
    logic [C2E_DIV_W-1:0] d;
    d = q - C2E_DIV_W'(16384);
    if (q > C2E_DIV_W'(49151)) begin
      return 16'sd32767;
    end
    return 16'(d);
  endfunction

  function automatic cord_t cord_prep(input logic signed [17:0] ya,
                                      input logic signed [17:0] xa);
    cord_t c;
    c.x = {{(C2E_CORD_W-34){xa[17]}}, xa, 16'h0000};
    c.y = {{(C2E_CORD_W-34){ya[17]}}, ya, 16'h0000};
    c.ang = '0;
    c.zero = (xa == '0) && (ya == '0);
    if (xa[17]) begin
      c.x = -c.x;
      c.y = -c.y;
      c.ang = C2E_HALF_TURN;
    end
    return c;
  endfunction

endpackage

[design/c2e_div_cell.sv]
// ----------------------------------------------------------------------------
// Restoring division cell
// Takes one dividend bit, subtracts the divisor where it fits and registers
// the partial remainder and quotient for the next cell.
// ----------------------------------------------------------------------------
module c2e_div_cell
  import c2e_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [C2E_REM_W-1:0] d,
  input  div_t                 a,
  output div_t                 q
);

  logic [C2E_REM_W:0] t;
  logic               ge;
  div_t               q_next;

  always_comb begin
    t = {a.rem, a.num[C2E_DIV_W-1]};
    ge = t >= {1'b0, d};
    q_next.rem = ge ? C2E_REM_W'(t - {1'b0, d}) : t[C2E_REM_W-1:0];
    q_next.num = {a.num[C2E_DIV_W-2:0], 1'b0};
    q_next.quo = {a.quo[C2E_DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

[design/c2e_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Square root cell
// One step of the bit-pair integer square root, registered.
// ----------------------------------------------------------------------------
module c2e_sqrt_cell
  import c2e_pkg::*;
#(
  parameter int STEP = 0
)
(
  input  logic  clk,
  input  logic  en,
  input  sqrt_t a,
  output sqrt_t q
);

  localparam logic [C2E_SQ_W-1:0] BIT = C2E_SQ_W'(1) << (30 - 2 * STEP);

  logic [C2E_SQ_W-1:0] rb;
  sqrt_t               q_next;

  always_comb begin
    rb = a.r + BIT;
    if (a.n >= rb) begin
      q_next.n = a.n - rb;
      q_next.r = (a.r >> 1) + BIT;
    end else begin
      q_next.n = a.n;
      q_next.r = a.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

[design/c2e_cordic_cell.sv]
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation toward the x axis with its angle step, registered.
// ----------------------------------------------------------------------------
module c2e_cordic_cell
  import c2e_pkg::*;
#(
  parameter int STEP = 0
)
(
  input  logic  clk,
  input  logic  en,
  input  cord_t a,
  output cord_t q
);

  logic signed [C2E_CORD_W-1:0] dx;
  logic signed [C2E_CORD_W-1:0] dy;
  logic                         pos;
  cord_t                        q_next;

  always_comb begin
    dx = a.y >>> STEP;
    dy = a.x >>> STEP;
    pos = !a.y[C2E_CORD_W-1] && (a.y != '0);
    q_next.zero = a.zero;
    if (pos) begin
      q_next.x = a.x + dx;
      q_next.y = a.y - dy;
      q_next.ang = a.ang + C2E_ATAN_TURNS[STEP];
    end else begin
      q_next.x = a.x - dx;
      q_next.y = a.y + dy;
      q_next.ang = a.ang - C2E_ATAN_TURNS[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

[design/cubemap_to_equirect_address.sv]
// ----------------------------------------------------------------------------
// Cubemap to equirectangular address generator
// Maps a cube face pixel to its source column, row and index in an
// equirectangular image and to its index in a six-face strip.
//
//   channel   direction   handshake               word
//   in        input       in_valid / in_ready     in_word_t
//   out       output      out_valid / out_ready   out_word_t
//   cfg       input       cfg_write               cfg_index, cfg_data
//
// One word is accepted per cycle unless a held result stalls; out_valid rises
// once its word has passed the division, square root and polar CORDIC cell
// rows in series. The longitude CORDIC row runs beside the square root.
// Reset clears all valid bits and loads the default register values.
// A held result stalls every stage at once, and in_ready drops with it.
// ----------------------------------------------------------------------------
`include "cubemap_to_equirect_address_assert.svh"

module cubemap_to_equirect_address
  import c2e_pkg::*;
#(
  parameter int ANGLE_BITS = C2E_ANGLE_BITS
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_word_t                 in_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_word_t                out_word,
  input  logic                     cfg_write,
  input  logic [C2E_CFG_IDX_W-1:0] cfg_index,
  input  logic [C2E_CFG_W-1:0]     cfg_data
);

  localparam int S_DIV_END = C2E_DIV_STEPS;
  localparam int S_VEC = S_DIV_END + 1;
  localparam int S_PREP = S_VEC + 1;
  localparam int S_SUM = S_PREP + 1;
  localparam int S_SQRT_END = S_SUM + C2E_SQRT_STEPS;
  localparam int S_PPREP = S_SQRT_END + 1;
  localparam int S_LON = S_PREP + C2E_CORD_STEPS + 1;
  localparam int S_POL = S_PPREP + C2E_CORD_STEPS + 1;
  localparam int S_MUL = S_POL + 1;
  localparam int S_RED = S_MUL + 1;
  localparam int S_IDX = S_RED + 1;
  localparam int S_OUT = S_IDX + 1;
  localparam int PW = ANGLE_BITS + 14;
  localparam logic [PW-1:0] HALF = PW'(1) << (ANGLE_BITS - 1);
  localparam logic [31:0] ROUND = 32'(1) << (31 - ANGLE_BITS);

  typedef struct packed {
    logic [2:0]             face;
    logic [11:0]            column;
    logic [11:0]            row;
    logic signed [15:0]     x;
    logic signed [15:0]     y;
    logic signed [15:0]     z;
    logic [ANGLE_BITS-1:0]  lon;
    logic [ANGLE_BITS-1:0]  pol;
  } side_t;

  logic [12:0] face_size;
  logic [13:0] source_width;
  logic [12:0] source_height;
  logic [12:0] s_eff;
  logic [13:0] w_eff;
  logic [12:0] h_eff;
  logic        adv;
  logic [S_OUT:0] valid;

  side_t side [0:S_POL];
  div_t  du [0:C2E_DIV_STEPS];
  div_t  dv [0:C2E_DIV_STEPS];
  cord_t cl [0:C2E_CORD_STEPS];
  cord_t cp [0:C2E_CORD_STEPS];
  sqrt_t sr [0:C2E_SQRT_STEPS];

  logic signed [31:0] sqx;
  logic signed [31:0] sqz;
  logic [C2E_SQ_W-1:0] nsum;
  logic [16:0] rho;
  logic [C2E_REM_W-1:0] d2s;
  side_t vec_side;
  side_t lon_side;
  side_t pol_side;
  logic signed [15:0] cu;
  logic signed [15:0] cv;
  logic [31:0] lon_ang;
  logic [31:0] pol_ang;

  logic [PW-1:0] prod_c;
  logic [PW-1:0] prod_r;
  logic [27:0]   tgt_a;
  logic [15:0]   tgt_b;
  logic [14:0]   row6;
  logic [13:0]   scol_raw;
  logic [13:0]   srow_raw;
  logic [13:0]   srow_1;
  logic [13:0]   srow_2;
  logic [12:0]   scol_r;
  logic [11:0]   srow_r;
  logic [26:0]   tgt_r;
  logic [25:0]   sidx_p;
  logic [12:0]   scol_i;
  logic [11:0]   srow_i;
  logic [26:0]   tgt_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_size <= 13'd512;
      source_width <= 14'd2048;
      source_height <= 13'd1024;
    end else if (cfg_write) begin
      unique case (cfg_index)
        C2E_REG_FACE_SIZE:     face_size <= cfg_data[12:0];
        C2E_REG_SOURCE_WIDTH:  source_width <= cfg_data;
        C2E_REG_SOURCE_HEIGHT: source_height <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    s_eff = (face_size == '0) ? 13'd1 :
            (face_size > 13'(C2E_MAX_FACE_SIZE)) ? 13'(C2E_MAX_FACE_SIZE) : face_size;
    w_eff = (source_width == '0) ? 14'd1 :
            (source_width > 14'(C2E_MAX_SOURCE_WIDTH)) ? 14'(C2E_MAX_SOURCE_WIDTH) :
            source_width;
    h_eff = (source_height == '0) ? 13'd1 :
            (source_height > 13'(C2E_MAX_SOURCE_WIDTH / 2)) ?
            13'(C2E_MAX_SOURCE_WIDTH / 2) : source_height;
    d2s = {s_eff, 1'b0};
  end

  assign adv = !valid[S_OUT] || out_ready;
  assign in_ready = adv;
  assign out_valid = valid[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[S_OUT-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0].face <= (in_word.face > C2E_FACE_NZ) ? C2E_FACE_NZ : in_word.face;
      side[0].column <= in_word.column;
      side[0].row <= in_word.row;
      side[0].x <= '0;
      side[0].y <= '0;
      side[0].z <= '0;
      side[0].lon <= '0;
      side[0].pol <= '0;
      du[0].rem <= '0;
      du[0].num <= C2E_DIV_W'({in_word.column, 1'b1, 15'h0000}) + C2E_DIV_W'(s_eff);
      du[0].quo <= '0;
      dv[0].rem <= '0;
      dv[0].num <= C2E_DIV_W'({in_word.row, 1'b1, 15'h0000}) + C2E_DIV_W'(s_eff);
      dv[0].quo <= '0;
    end
  end

  for (genvar k = 0; k < C2E_DIV_STEPS; k++) begin : g_div
    c2e_div_cell u_cell_u (.clk(clk), .en(adv), .d(d2s), .a(du[k]), .q(du[k+1]));
    c2e_div_cell u_cell_v (.clk(clk), .en(adv), .d(d2s), .a(dv[k]), .q(dv[k+1]));
  end

  always_comb begin
    cu = face_coord_sat(du[C2E_DIV_STEPS].quo);
    cv = face_coord_sat(dv[C2E_DIV_STEPS].quo);
    vec_side = side[S_DIV_END];
    unique case (side[S_DIV_END].face)
      C2E_FACE_PX: begin
        vec_side.x = C2E_UNIT;
        vec_side.y = -cv;
        vec_side.z = cu;
      end
      C2E_FACE_NX: begin
        vec_side.x = -C2E_UNIT;
        vec_side.y = -cv;
        vec_side.z = -cu;
      end
      C2E_FACE_PY: begin
        vec_side.x = -cu;
        vec_side.y = C2E_UNIT;
        vec_side.z = cv;
      end
      C2E_FACE_NY: begin
        vec_side.x = -cu;
        vec_side.y = -C2E_UNIT;
        vec_side.z = -cv;
      end
      C2E_FACE_PZ: begin
        vec_side.x = -cu;
        vec_side.y = -cv;
        vec_side.z = C2E_UNIT;
      end
      default: begin
        vec_side.x = cu;
        vec_side.y = -cv;
        vec_side.z = -C2E_UNIT;
      end
    endcase
    lon_ang = (cl[C2E_CORD_STEPS].zero ? 32'h0 : cl[C2E_CORD_STEPS].ang) + ROUND;
    pol_ang = (cp[C2E_CORD_STEPS].zero ? 32'h0 : cp[C2E_CORD_STEPS].ang) + ROUND;
    lon_side = side[S_LON-1];
    lon_side.lon = lon_ang[31 -: ANGLE_BITS];
    pol_side = side[S_POL-1];
    pol_side.pol = pol_ang[31 -: ANGLE_BITS];
    rho = 17'(sr[C2E_SQRT_STEPS].r +
              C2E_SQ_W'(sr[C2E_SQRT_STEPS].n > sr[C2E_SQRT_STEPS].r));
  end

  for (genvar k = 1; k <= S_POL; k++) begin : g_side
    if (k == S_VEC) begin : g_vec
      always_ff @(posedge clk) begin
        if (adv) begin
          side[k] <= vec_side;
        end
      end
    end else if (k == S_LON) begin : g_lon
      always_ff @(posedge clk) begin
        if (adv) begin
          side[k] <= lon_side;
        end
      end
    end else if (k == S_POL) begin : g_pol
      always_ff @(posedge clk) begin
        if (adv) begin
          side[k] <= pol_side;
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (adv) begin
          side[k] <= side[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cl[0] <= cord_prep(18'(side[S_VEC].z), 18'(side[S_VEC].x));
      sqx <= side[S_VEC].x * side[S_VEC].x;
      sqz <= side[S_VEC].z * side[S_VEC].z;
      nsum <= unsigned'(sqx) + unsigned'(sqz);
      cp[0] <= cord_prep(signed'({1'b0, rho}), 18'(side[S_SQRT_END].y));
    end
  end

  assign sr[0].n = nsum;
  assign sr[0].r = '0;

  for (genvar k = 0; k < C2E_SQRT_STEPS; k++) begin : g_sqrt
    c2e_sqrt_cell #(.STEP(k)) u_cell (.clk(clk), .en(adv), .a(sr[k]), .q(sr[k+1]));
  end

  for (genvar k = 0; k < C2E_CORD_STEPS; k++) begin : g_cordic
    c2e_cordic_cell #(.STEP(k)) u_lon (.clk(clk), .en(adv), .a(cl[k]), .q(cl[k+1]));
    c2e_cordic_cell #(.STEP(k)) u_pol (.clk(clk), .en(adv), .a(cp[k]), .q(cp[k+1]));
  end

  always_comb begin
    row6 = 15'({side[S_POL].row, 2'b00}) + 15'({side[S_POL].row, 1'b0});
    scol_raw = prod_c[PW-1:ANGLE_BITS];
    srow_raw = prod_r[PW-1:ANGLE_BITS];
    srow_1 = (srow_raw >= {1'b0, h_eff}) ? srow_raw - {1'b0, h_eff} : srow_raw;
    srow_2 = (srow_1 >= {1'b0, h_eff}) ? srow_1 - {1'b0, h_eff} : srow_1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_c <= PW'(PW'(side[S_POL].lon) * PW'(w_eff) + HALF);
      prod_r <= PW'(PW'(side[S_POL].pol) * PW'({h_eff, 1'b0}) + HALF);
      tgt_a <= 28'(28'(row6) * 28'(s_eff));
      tgt_b <= 16'(16'(side[S_POL].face) * 16'(s_eff) + 16'(side[S_POL].column));
      scol_r <= (scol_raw == w_eff) ? 13'd0 : 13'(scol_raw);
      srow_r <= 12'(srow_2);
      tgt_r <= 27'(tgt_a + 28'(tgt_b));
      sidx_p <= 26'(26'(srow_r) * 26'(w_eff));
      scol_i <= scol_r;
      srow_i <= srow_r;
      tgt_i <= tgt_r;
      out_word.source_column <= scol_i;
      out_word.source_row <= srow_i;
      out_word.source_index <= 25'(sidx_p + 26'(scol_i));
      out_word.target_index <= tgt_i;
    end
  end

  `C2E_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "pipeline not empty after reset")
  `C2E_ASSERT(a_accept_enters, in_valid && in_ready |=> valid[0], "accepted word was lost")
  `C2E_ASSERT(a_stall_holds, !in_ready |=> $stable(valid), "stalled pipeline moved")
  `C2E_ASSERT(a_col_range, out_valid |-> out_word.source_column < w_eff, "column not wrapped")
  `C2E_ASSERT(a_row_range, out_valid |-> out_word.source_row < h_eff, "row not wrapped")

endmodule
